// ===== src/mie_pkg.sv =====
`timescale 1ns / 1ps
package mie_pkg;

    localparam logic [31:0] START_RESET = 32'h0040_0000;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_OVERFLOW = 3'd1;
    localparam logic [2:0] ST_MISALIGN = 3'd2;
    localparam logic [2:0] ST_DIVZERO  = 3'd3;
    localparam logic [2:0] ST_UNKNOWN  = 3'd4;

    // primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'h00;
    localparam logic [5:0] OP_REGIMM  = 6'h01;
    localparam logic [5:0] OP_J       = 6'h02;
    localparam logic [5:0] OP_JAL     = 6'h03;
    localparam logic [5:0] OP_BEQ     = 6'h04;
    localparam logic [5:0] OP_BNE     = 6'h05;
    localparam logic [5:0] OP_BLEZ    = 6'h06;
    localparam logic [5:0] OP_BGTZ    = 6'h07;
    localparam logic [5:0] OP_ADDI    = 6'h08;
    localparam logic [5:0] OP_ADDIU   = 6'h09;
    localparam logic [5:0] OP_SLTI    = 6'h0A;
    localparam logic [5:0] OP_SLTIU   = 6'h0B;
    localparam logic [5:0] OP_ANDI    = 6'h0C;
    localparam logic [5:0] OP_ORI     = 6'h0D;
    localparam logic [5:0] OP_XORI    = 6'h0E;
    localparam logic [5:0] OP_LUI     = 6'h0F;
    localparam logic [5:0] OP_LB      = 6'h20;
    localparam logic [5:0] OP_LH      = 6'h21;
    localparam logic [5:0] OP_LW      = 6'h23;
    localparam logic [5:0] OP_LBU     = 6'h24;
    localparam logic [5:0] OP_LHU     = 6'h25;
    localparam logic [5:0] OP_SB      = 6'h28;
    localparam logic [5:0] OP_SH      = 6'h29;
    localparam logic [5:0] OP_SW      = 6'h2B;

    // special function codes
    localparam logic [5:0] FN_SLL     = 6'h00;
    localparam logic [5:0] FN_SRL     = 6'h02;
    localparam logic [5:0] FN_SRA     = 6'h03;
    localparam logic [5:0] FN_SLLV    = 6'h04;
    localparam logic [5:0] FN_SRLV    = 6'h06;
    localparam logic [5:0] FN_SRAV    = 6'h07;
    localparam logic [5:0] FN_JR      = 6'h08;
    localparam logic [5:0] FN_JALR    = 6'h09;
    localparam logic [5:0] FN_SYSCALL = 6'h0C;
    localparam logic [5:0] FN_MFHI    = 6'h10;
    localparam logic [5:0] FN_MTHI    = 6'h11;
    localparam logic [5:0] FN_MFLO    = 6'h12;
    localparam logic [5:0] FN_MTLO    = 6'h13;
    localparam logic [5:0] FN_MULT    = 6'h18;
    localparam logic [5:0] FN_MULTU   = 6'h19;
    localparam logic [5:0] FN_DIV     = 6'h1A;
    localparam logic [5:0] FN_DIVU    = 6'h1B;
    localparam logic [5:0] FN_ADD     = 6'h20;
    localparam logic [5:0] FN_ADDU    = 6'h21;
    localparam logic [5:0] FN_SUB     = 6'h22;
    localparam logic [5:0] FN_SUBU    = 6'h23;
    localparam logic [5:0] FN_AND     = 6'h24;
    localparam logic [5:0] FN_OR      = 6'h25;
    localparam logic [5:0] FN_XOR     = 6'h26;
    localparam logic [5:0] FN_NOR     = 6'h27;
    localparam logic [5:0] FN_SLT     = 6'h2A;
    localparam logic [5:0] FN_SLTU    = 6'h2B;

    // regimm codes
    localparam logic [4:0] RI_BLTZ    = 5'h00;
    localparam logic [4:0] RI_BGEZ    = 5'h01;
    localparam logic [4:0] RI_BLTZAL  = 5'h10;
    localparam logic [4:0] RI_BGEZAL  = 5'h11;

    localparam logic [31:0] SYSCALL_EXIT = 32'd10;
    localparam logic [4:0]  REG_V0      = 5'd2;
    localparam logic [4:0]  REG_RA      = 5'd31;

    typedef enum logic [1:0] {
        MD_MULT  = 2'd0,
        MD_MULTU = 2'd1,
        MD_DIV   = 2'd2,
        MD_DIVU  = 2'd3
    } t_md_op;

    typedef struct packed {
        logic   start;
        t_md_op op;
    } t_md_req;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_READ = 6'b000010,
        S_EXEC = 6'b000100,
        S_MEM  = 6'b001000,
        S_MD   = 6'b010000,
        S_WB   = 6'b100000
    } t_state;

endpackage

// ===== src/mie_ram.sv =====
`timescale 1ns / 1ps
module mie_ram #(
    parameter int W = 32,
    parameter int D = 32
) (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [$clog2(D)-1:0] i_waddr,
    input  logic [W-1:0]         i_wdata,
    input  logic [$clog2(D)-1:0] i_raddr_a,
    output logic [W-1:0]         o_rdata_a,
    input  logic [$clog2(D)-1:0] i_raddr_b,
    output logic [W-1:0]         o_rdata_b
);
    logic [W-1:0] r_mem [D];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata_a <= r_mem[i_raddr_a];
        o_rdata_b <= r_mem[i_raddr_b];
    end
endmodule

// ===== src/mie_muldiv.sv =====
`timescale 1ns / 1ps
module mie_muldiv
    import mie_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_md_req     i_req,
    input  logic [31:0] i_a,
    input  logic [31:0] i_b,
    output logic        o_done,
    output logic [31:0] o_hi,
    output logic [31:0] o_lo
);
    logic        r_busy, r_fix, r_done;
    logic [4:0]  r_cnt;
    logic        r_div, r_neg_q, r_neg_r;
    logic [31:0] r_hi, r_lo, r_d;

    logic        sgn, sa, sb;
    logic [31:0] ma, mb;
    logic [32:0] msum;
    logic [32:0] shifted;
    logic [33:0] trial;
    logic [63:0] pneg;

    always_comb begin
        sgn     = (i_req.op == MD_MULT) || (i_req.op == MD_DIV);
        sa      = sgn & i_a[31];
        sb      = sgn & i_b[31];
        ma      = sa ? (32'd0 - i_a) : i_a;
        mb      = sb ? (32'd0 - i_b) : i_b;
        msum    = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_d} : 33'd0);
        shifted = {r_hi, r_lo[31]};
        trial   = {1'b0, shifted} - {2'b00, r_d};
        pneg    = 64'd0 - {r_hi, r_lo};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fix  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy  <= 1'b1;
                r_cnt   <= '0;
                r_div   <= (i_req.op == MD_DIV) || (i_req.op == MD_DIVU);
                r_neg_q <= sa ^ sb;
                r_neg_r <= sa;
                r_hi    <= '0;
                r_lo    <= ma;
                r_d     <= mb;
            end else if (r_busy) begin
                if (r_div) begin
                    // restoring step: one quotient bit per cycle
                    if (!trial[33]) begin
                        r_hi <= trial[31:0];
                        r_lo <= {r_lo[30:0], 1'b1};
                    end else begin
                        r_hi <= shifted[31:0];
                        r_lo <= {r_lo[30:0], 1'b0};
                    end
                end else begin
                    {r_hi, r_lo} <= {msum, r_lo[31:1]};
                end
                r_cnt <= r_cnt + 5'd1;
                if (r_cnt == 5'd31) begin
                    r_busy <= 1'b0;
                    r_fix  <= 1'b1;
                end
            end else if (r_fix) begin
                r_fix  <= 1'b0;
                r_done <= 1'b1;
                if (r_div) begin
                    if (r_neg_q) r_lo <= 32'd0 - r_lo;
                    if (r_neg_r) r_hi <= 32'd0 - r_hi;
                end else if (r_neg_q) begin
                    {r_hi, r_lo} <= pneg;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_hi   = r_hi;
    assign o_lo   = r_lo;
endmodule

// ===== src/mips_integer_instruction_execute.sv =====
`timescale 1ns / 1ps
// mips32 integer execute unit
// input channel: i_in_valid / o_in_stall carry one instruction word, taken at an
//   edge with valid high and stall low; it is the word fetched at the current pc
// output channel: o_out_valid / i_out_stall carry one result per request: next
//   pc, register write, store flag, status and the halted flag
// states: accept, read, execute and write back for most instructions; loads and
//   byte/halfword stores add a memory step (data memory read port), mult/div a
//   wait on the 1-bit-per-cycle shared multiply/divide unit
// only one request is in flight; o_in_stall is high from accept until write back
// a result waits in the output register while the receiver stalls; a new request
//   may be taken meanwhile, but its write back holds until the slot frees
// config: i_cfg_we with i_cfg_data loads the program counter; the user must do so only while idle (not enforced)
// reset: pc to 0x0040_0000, registers, hi, lo and halt cleared; data memory is
//   then cleared word by word, with o_in_stall held high (depth DMEM_WORDS,
//   a power of two)
// once halted every request returns the held pc with only the halted flag set
module mips_integer_instruction_execute
    import mie_pkg::*;
#(
    parameter int DMEM_WORDS = 1024
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [31:0] i_instruction,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_next_pc,
    output logic        o_reg_written,
    output logic [4:0]  o_reg_index,
    output logic [31:0] o_reg_value,
    output logic        o_stored,
    output logic [2:0]  o_status,
    output logic        o_halted
);
    localparam int AW = $clog2(DMEM_WORDS);

    t_state      r_state, n_state;
    logic [31:0] r_ins, r_pc, r_hi, r_lo;
    logic        r_halt;
    logic [31:0] r_rf_valid;

    // data memory clearing pass after reset
    logic          r_clr;
    logic [AW-1:0] r_clr_addr;

    // results held between execute and write back
    logic        r_wr, r_st, r_halt_set;
    logic [4:0]  r_widx;
    logic [31:0] r_wval, r_npc, r_b, r_addr;
    logic [2:0]  r_status;

    logic        r_out_valid;
    logic [31:0] r_o_pc, r_o_val;
    logic        r_o_wr, r_o_st, r_o_halt;
    logic [4:0]  r_o_idx;
    logic [2:0]  r_o_status;

    // field decode
    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sh;
    logic [31:0] imm, sx;
    assign op  = r_ins[31:26];
    assign rs  = r_ins[25:21];
    assign rt  = r_ins[20:16];
    assign rd  = r_ins[15:11];
    assign sh  = r_ins[10:6];
    assign fn  = r_ins[5:0];
    assign imm = {16'd0, r_ins[15:0]};
    assign sx  = {{16{r_ins[15]}}, r_ins[15:0]};

    // register file, two read ports
    logic        rf_we;
    logic [4:0]  rf_ra_a, rf_ra_b;
    logic [31:0] rf_rd_a, rf_rd_b, a, b;
    logic        is_syscall;
    assign is_syscall = (op == OP_SPECIAL) && (fn == FN_SYSCALL);
    assign rf_ra_a    = is_syscall ? REG_V0 : rs;
    assign rf_ra_b    = rt;
    assign a = r_rf_valid[rf_ra_a] ? rf_rd_a : 32'd0;
    assign b = r_rf_valid[rf_ra_b] ? rf_rd_b : 32'd0;

    logic out_free;
    assign out_free = !r_out_valid || !i_out_stall;
    assign rf_we    = (r_state == S_WB) && out_free && r_wr && (r_widx != 5'd0);

    mie_ram #(.W(32), .D(32)) u_rf (
        .i_clk     (i_clk),
        .i_we      (rf_we),
        .i_waddr   (r_widx),
        .i_wdata   (r_wval),
        .i_raddr_a (rf_ra_a),
        .o_rdata_a (rf_rd_a),
        .i_raddr_b (rf_ra_b),
        .o_rdata_b (rf_rd_b)
    );

    // data memory
    logic          dm_we;
    logic [AW-1:0] dm_waddr, dm_raddr, dm_unused_addr;
    logic [31:0]   dm_wdata, dm_rdata, dm_unused;
    logic [31:0]   addr;
    assign addr           = a + sx;
    assign dm_raddr       = addr[AW+1:2];
    assign dm_unused_addr = '0;

    mie_ram #(.W(32), .D(DMEM_WORDS)) u_dmem (
        .i_clk     (i_clk),
        .i_we      (dm_we),
        .i_waddr   (dm_waddr),
        .i_wdata   (dm_wdata),
        .i_raddr_a (dm_raddr),
        .o_rdata_a (dm_rdata),
        .i_raddr_b (dm_unused_addr),
        .o_rdata_b (dm_unused)
    );

    // multiply / divide unit
    t_md_req     md_req;
    logic        md_done;
    logic [31:0] md_hi, md_lo;

    mie_muldiv u_md (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (md_req),
        .i_a     (a),
        .i_b     (b),
        .o_done  (md_done),
        .o_hi    (md_hi),
        .o_lo    (md_lo)
    );

    // execute stage
    logic        e_wr, e_st, e_halt, e_mem, e_md;
    logic [4:0]  e_widx;
    logic [31:0] e_wval, e_npc, pc4, tgt, rsum, rdif, isum;
    logic [2:0]  e_status;
    logic        e_hi_we, e_lo_we;

    assign pc4  = r_pc + 32'd4;
    assign tgt  = pc4 + {sx[29:0], 2'b00};
    assign rsum = a + b;
    assign rdif = a - b;
    assign isum = a + sx;

    always_comb begin
        e_wr     = 1'b0;
        e_st     = 1'b0;
        e_halt   = 1'b0;
        e_mem    = 1'b0;
        e_md     = 1'b0;
        e_widx   = rd;
        e_wval   = 32'd0;
        e_npc    = pc4;
        e_status = ST_OK;
        e_hi_we  = 1'b0;
        e_lo_we  = 1'b0;
        md_req.start = 1'b0;
        md_req.op    = MD_MULT;
        case (op)
            OP_SPECIAL: begin
                case (fn)
                    FN_ADD: begin
                        if ((~(a ^ b) & (a ^ rsum)) >> 31 != 32'd0) e_status = ST_OVERFLOW;
                        else begin e_wr = 1'b1; e_wval = rsum; end
                    end
                    FN_ADDU: begin e_wr = 1'b1; e_wval = rsum; end
                    FN_SUB: begin
                        if (((a ^ b) & (a ^ rdif)) >> 31 != 32'd0) e_status = ST_OVERFLOW;
                        else begin e_wr = 1'b1; e_wval = rdif; end
                    end
                    FN_SUBU: begin e_wr = 1'b1; e_wval = rdif; end
                    FN_AND:  begin e_wr = 1'b1; e_wval = a & b; end
                    FN_OR:   begin e_wr = 1'b1; e_wval = a | b; end
                    FN_XOR:  begin e_wr = 1'b1; e_wval = a ^ b; end
                    FN_NOR:  begin e_wr = 1'b1; e_wval = ~(a | b); end
                    FN_SLT:  begin e_wr = 1'b1; e_wval = {31'd0, $signed(a) < $signed(b)}; end
                    FN_SLTU: begin e_wr = 1'b1; e_wval = {31'd0, a < b}; end
                    FN_SLL:  begin e_wr = 1'b1; e_wval = b << sh; end
                    FN_SRL:  begin e_wr = 1'b1; e_wval = b >> sh; end
                    FN_SRA:  begin e_wr = 1'b1; e_wval = $unsigned($signed(b) >>> sh); end
                    FN_SLLV: begin e_wr = 1'b1; e_wval = b << a[4:0]; end
                    FN_SRLV: begin e_wr = 1'b1; e_wval = b >> a[4:0]; end
                    FN_SRAV: begin e_wr = 1'b1; e_wval = $unsigned($signed(b) >>> a[4:0]); end
                    FN_MULT:  begin e_md = 1'b1; md_req.start = 1'b1; md_req.op = MD_MULT; end
                    FN_MULTU: begin e_md = 1'b1; md_req.start = 1'b1; md_req.op = MD_MULTU; end
                    FN_DIV: begin
                        if (b == 32'd0) e_status = ST_DIVZERO;
                        else begin e_md = 1'b1; md_req.start = 1'b1; md_req.op = MD_DIV; end
                    end
                    FN_DIVU: begin
                        if (b == 32'd0) e_status = ST_DIVZERO;
                        else begin e_md = 1'b1; md_req.start = 1'b1; md_req.op = MD_DIVU; end
                    end
                    FN_MFHI: begin e_wr = 1'b1; e_wval = r_hi; end
                    FN_MFLO: begin e_wr = 1'b1; e_wval = r_lo; end
                    FN_MTHI: e_hi_we = 1'b1;
                    FN_MTLO: e_lo_we = 1'b1;
                    FN_JR: begin
                        if (a[1:0] != 2'b00) e_status = ST_MISALIGN;
                        else e_npc = a;
                    end
                    FN_JALR: begin
                        if (a[1:0] != 2'b00) e_status = ST_MISALIGN;
                        else begin e_wr = 1'b1; e_wval = pc4; e_npc = a; end
                    end
                    FN_SYSCALL: e_halt = (a == SYSCALL_EXIT);
                    default: e_status = ST_UNKNOWN;
                endcase
            end
            OP_REGIMM: begin
                case (rt)
                    RI_BLTZ: if (a[31]) e_npc = tgt;
                    RI_BGEZ: if (!a[31]) e_npc = tgt;
                    RI_BLTZAL: begin
                        e_wr = 1'b1; e_widx = REG_RA; e_wval = pc4;
                        if (a[31]) e_npc = tgt;
                    end
                    RI_BGEZAL: begin
                        e_wr = 1'b1; e_widx = REG_RA; e_wval = pc4;
                        if (!a[31]) e_npc = tgt;
                    end
                    default: e_status = ST_UNKNOWN;
                endcase
            end
            OP_J:   e_npc = {pc4[31:28], r_ins[25:0], 2'b00};
            OP_JAL: begin
                e_wr = 1'b1; e_widx = REG_RA; e_wval = pc4;
                e_npc = {pc4[31:28], r_ins[25:0], 2'b00};
            end
            OP_BEQ:  if (a == b) e_npc = tgt;
            OP_BNE:  if (a != b) e_npc = tgt;
            OP_BLEZ: if (a[31] || a == 32'd0) e_npc = tgt;
            OP_BGTZ: if (!a[31] && a != 32'd0) e_npc = tgt;
            OP_ADDI: begin
                e_widx = rt;
                if ((~(a ^ sx) & (a ^ isum)) >> 31 != 32'd0) e_status = ST_OVERFLOW;
                else begin e_wr = 1'b1; e_wval = isum; end
            end
            OP_ADDIU: begin e_wr = 1'b1; e_widx = rt; e_wval = isum; end
            OP_SLTI:  begin e_wr = 1'b1; e_widx = rt; e_wval = {31'd0, $signed(a) < $signed(sx)}; end
            OP_SLTIU: begin e_wr = 1'b1; e_widx = rt; e_wval = {31'd0, a < sx}; end
            OP_ANDI:  begin e_wr = 1'b1; e_widx = rt; e_wval = a & imm; end
            OP_ORI:   begin e_wr = 1'b1; e_widx = rt; e_wval = a | imm; end
            OP_XORI:  begin e_wr = 1'b1; e_widx = rt; e_wval = a ^ imm; end
            OP_LUI:   begin e_wr = 1'b1; e_widx = rt; e_wval = {r_ins[15:0], 16'd0}; end
            OP_LB, OP_LBU, OP_SB: begin e_widx = rt; e_mem = 1'b1; end
            OP_LH, OP_LHU, OP_SH: begin
                e_widx = rt;
                if (addr[0]) e_status = ST_MISALIGN;
                else e_mem = 1'b1;
            end
            OP_LW: begin
                e_widx = rt;
                if (addr[1:0] != 2'b00) e_status = ST_MISALIGN;
                else e_mem = 1'b1;
            end
            OP_SW: begin
                if (addr[1:0] != 2'b00) e_status = ST_MISALIGN;
                else e_st = 1'b1;
            end
            default: e_status = ST_UNKNOWN;
        endcase
        // halted: nothing happens, pc held
        if (r_halt) begin
            e_wr = 1'b0; e_st = 1'b0; e_halt = 1'b0; e_mem = 1'b0; e_md = 1'b0;
            e_status = ST_OK; e_npc = r_pc; e_hi_we = 1'b0; e_lo_we = 1'b0;
            md_req.start = 1'b0;
        end
        // the shared unit is started once, in the execute cycle
        if (r_state != S_EXEC) md_req.start = 1'b0;
    end

    // memory stage: load extract and sub-word store merge
    logic [7:0]  m_byte;
    logic [15:0] m_half;
    logic [31:0] m_load, m_merge;
    always_comb begin
        m_byte  = dm_rdata[{r_addr[1:0], 3'b000} +: 8];
        m_half  = dm_rdata[{r_addr[1], 4'b0000} +: 16];
        m_merge = dm_rdata;
        case (r_ins[31:26])
            OP_LB:   m_load = {{24{m_byte[7]}}, m_byte};
            OP_LBU:  m_load = {24'd0, m_byte};
            OP_LH:   m_load = {{16{m_half[15]}}, m_half};
            OP_LHU:  m_load = {16'd0, m_half};
            default: m_load = dm_rdata;
        endcase
        if (r_ins[31:26] == OP_SB) m_merge[{r_addr[1:0], 3'b000} +: 8] = r_b[7:0];
        else m_merge[{r_addr[1], 4'b0000} +: 16] = r_b[15:0];
    end

    logic m_is_store;
    assign m_is_store = (r_ins[31:26] == OP_SB) || (r_ins[31:26] == OP_SH);

    always_comb begin
        dm_we    = 1'b0;
        dm_waddr = r_addr[AW+1:2];
        dm_wdata = r_b;
        if (r_clr) begin
            dm_we    = 1'b1;
            dm_waddr = r_clr_addr;
            dm_wdata = 32'd0;
        end else if (r_state == S_EXEC && e_st) begin
            dm_we    = 1'b1;
            dm_waddr = addr[AW+1:2];
            dm_wdata = b;
        end else if (r_state == S_MEM && m_is_store) begin
            dm_we    = 1'b1;
            dm_wdata = m_merge;
        end
    end

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_in_valid && !r_clr) n_state = S_READ;
            S_READ: n_state = S_EXEC;
            S_EXEC: begin
                if (e_mem)     n_state = S_MEM;
                else if (e_md) n_state = S_MD;
                else           n_state = S_WB;
            end
            S_MEM:  n_state = S_WB;
            S_MD:   if (md_done) n_state = S_WB;
            S_WB:   if (out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE) || r_clr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= START_RESET;
            r_hi        <= '0;
            r_lo        <= '0;
            r_halt      <= 1'b0;
            r_rf_valid  <= '0;
            r_out_valid <= 1'b0;
            r_clr       <= 1'b1;
            r_clr_addr  <= '0;
        end else begin
            r_state <= n_state;
            if (r_clr) begin
                r_clr_addr <= r_clr_addr + AW'(1);
                if (r_clr_addr == AW'(DMEM_WORDS - 1)) r_clr <= 1'b0;
            end
            if (i_cfg_we) r_pc <= i_cfg_data;
            if (r_state == S_EXEC) begin
                if (e_hi_we) r_hi <= a;
                if (e_lo_we) r_lo <= a;
            end
            if (r_state == S_MD && md_done) begin
                r_hi <= md_hi;
                r_lo <= md_lo;
            end
            if (r_state == S_WB && out_free) begin
                r_out_valid <= 1'b1;
                r_pc        <= r_npc;
                if (r_halt_set) r_halt <= 1'b1;
                if (rf_we) r_rf_valid[r_widx] <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && i_in_valid && !r_clr) r_ins <= i_instruction;
        if (r_state == S_EXEC) begin
            r_wr       <= e_wr;
            r_widx     <= e_widx;
            r_wval     <= e_wval;
            r_npc      <= e_npc;
            r_st       <= e_st;
            r_status   <= e_status;
            r_halt_set <= e_halt;
            r_b        <= b;
            r_addr     <= addr;
        end
        if (r_state == S_MEM) begin
            if (m_is_store) begin
                r_st <= 1'b1;
            end else begin
                r_wr   <= 1'b1;
                r_wval <= m_load;
            end
        end
        if (r_state == S_WB && out_free) begin
            r_o_pc     <= r_npc;
            r_o_wr     <= rf_we;
            r_o_idx    <= rf_we ? r_widx : 5'd0;
            r_o_val    <= rf_we ? r_wval : 32'd0;
            r_o_st     <= r_st;
            r_o_status <= r_status;
            r_o_halt   <= r_halt | r_halt_set;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_next_pc     = r_o_pc;
    assign o_reg_written = r_o_wr;
    assign o_reg_index   = r_o_idx;
    assign o_reg_value   = r_o_val;
    assign o_stored      = r_o_st;
    assign o_status      = r_o_status;
    assign o_halted      = r_o_halt;

    // a result appears only out of write back
    a_out_from_wb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(r_state == S_WB))
        else $error("result without write back");

    // register zero is never written
    a_no_r0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rf_we |-> (r_widx != 5'd0))
        else $error("write to register zero");

    // the shared unit finishes only while the sequencer waits for it
    a_md_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        md_done |-> (r_state == S_MD))
        else $error("unexpected multiply/divide completion");

    // halt is sticky
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halt flag cleared");
endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
    import mie_pkg::*;

    // one result as the block reports it
    typedef struct packed {
        logic [31:0] npc;
        logic        wr;
        logic [4:0]  idx;
        logic [31:0] val;
        logic        st;
        logic [2:0]  status;
        logic        halted;
    } exec_result_t;

    // row of the directed table: typed rows carry their own expected result
    typedef struct {
        logic [31:0]  ins;
        logic         typed;
        exec_result_t res;
    } dir_row_t;

    localparam int WATCHDOG_LIMIT = 4000;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [31:0] i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [31:0] i_instruction;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_next_pc;
    logic        o_reg_written;
    logic [4:0]  o_reg_index;
    logic [31:0] o_reg_value;
    logic        o_stored;
    logic [2:0]  o_status;
    logic        o_halted;

    mips_integer_instruction_execute dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_instruction (i_instruction),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_next_pc     (o_next_pc),
        .o_reg_written (o_reg_written),
        .o_reg_index   (o_reg_index),
        .o_reg_value   (o_reg_value),
        .o_stored      (o_stored),
        .o_status      (o_status),
        .o_halted      (o_halted)
    );

    // architectural state of the predicted machine
    logic [31:0] gpr [32];
    logic [31:0] pc_q;
    logic [31:0] hi_q;
    logic [31:0] lo_q;
    logic [31:0] dmem [1024];
    logic        dmem_written [1024];
    int          written_words [$];
    logic        halt_seen;

    exec_result_t result_q [$];
    dir_row_t     dir_rows [$];

    int send_idle_pct;
    int recv_idle_pct;
    int mismatches;
    int requests_sent;
    int results_checked;
    int idle_cycles;

    // pools that keep most random words well formed
    logic [5:0] op_pool [24] = '{OP_SPECIAL, OP_REGIMM, OP_J, OP_JAL, OP_BEQ, OP_BNE,
        OP_BLEZ, OP_BGTZ, OP_ADDI, OP_ADDIU, OP_SLTI, OP_SLTIU, OP_ANDI, OP_ORI,
        OP_XORI, OP_LUI, OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU, OP_SB, OP_SH, OP_SW};
    logic [5:0] fn_pool [27] = '{FN_SLL, FN_SRL, FN_SRA, FN_SLLV, FN_SRLV, FN_SRAV,
        FN_JR, FN_JALR, FN_SYSCALL, FN_MFHI, FN_MTHI, FN_MFLO, FN_MTLO, FN_MULT,
        FN_MULTU, FN_DIV, FN_DIVU, FN_ADD, FN_ADDU, FN_SUB, FN_SUBU, FN_AND, FN_OR,
        FN_XOR, FN_NOR, FN_SLT, FN_SLTU};
    logic [4:0] ri_pool [4] = '{RI_BLTZ, RI_BGEZ, RI_BLTZAL, RI_BGEZAL};

    // free-running clock, 2 ns period
    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [31:0] r_word(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                           logic [4:0] sh, logic [5:0] fn);
        return {OP_SPECIAL, rs, rt, rd, sh, fn};
    endfunction

    function automatic logic [31:0] i_word(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                           logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    function automatic exec_result_t typed_result(logic [31:0] npc, logic [4:0] idx,
                                                  logic [31:0] val, logic [2:0] status);
        exec_result_t res;
        res = '0;
        res.npc = npc;
        res.wr = (idx != 5'd0);
        res.idx = idx;
        res.val = val;
        res.status = status;
        return res;
    endfunction

    task automatic add_row(logic [31:0] ins, logic typed, exec_result_t res);
        dir_row_t row;
        row.ins = ins;
        row.typed = typed;
        row.res = res;
        dir_rows.push_back(row);
    endtask

    // executes one instruction word on the predicted state
    function automatic exec_result_t execute_word(logic [31:0] ins);
        logic [5:0]   op, fn;
        logic [4:0]   rs, rt, rd, sh;
        logic [15:0]  imm;
        logic [31:0]  a, b, se, npc, r, addr, w, tgt, ma, mb, q, m;
        logic [63:0]  p;
        logic         wr, st;
        logic [4:0]   idx;
        logic [31:0]  val;
        logic [2:0]   status;
        int           lane, wi;
        exec_result_t res;
        res = '0;
        if (halt_seen) begin
            res.npc = pc_q;
            res.halted = 1'b1;
            return res;
        end
        op = ins[31:26]; rs = ins[25:21]; rt = ins[20:16]; rd = ins[15:11];
        sh = ins[10:6]; fn = ins[5:0]; imm = ins[15:0];
        a = gpr[rs]; b = gpr[rt];
        se = {{16{imm[15]}}, imm};
        npc = pc_q + 32'd4;
        addr = a + se;
        wi = int'(addr[11:2]);
        wr = 1'b0; st = 1'b0; idx = 5'd0; val = '0; status = ST_OK;
        case (op)
            OP_SPECIAL: begin
                case (fn)
                    FN_ADD: begin
                        r = a + b;
                        if (~(a[31] ^ b[31]) & (a[31] ^ r[31])) status = ST_OVERFLOW;
                        else begin wr = 1; idx = rd; val = r; end
                    end
                    FN_ADDU: begin wr = 1; idx = rd; val = a + b; end
                    FN_SUB: begin
                        r = a - b;
                        if ((a[31] ^ b[31]) & (a[31] ^ r[31])) status = ST_OVERFLOW;
                        else begin wr = 1; idx = rd; val = r; end
                    end
                    FN_SUBU: begin wr = 1; idx = rd; val = a - b; end
                    FN_AND:  begin wr = 1; idx = rd; val = a & b; end
                    FN_OR:   begin wr = 1; idx = rd; val = a | b; end
                    FN_XOR:  begin wr = 1; idx = rd; val = a ^ b; end
                    FN_NOR:  begin wr = 1; idx = rd; val = ~(a | b); end
                    FN_SLT:  begin wr = 1; idx = rd; val = ($signed(a) < $signed(b)); end
                    FN_SLTU: begin wr = 1; idx = rd; val = (a < b); end
                    FN_SLL:  begin wr = 1; idx = rd; val = b << sh; end
                    FN_SRL:  begin wr = 1; idx = rd; val = b >> sh; end
                    FN_SRA:  begin wr = 1; idx = rd; val = $signed(b) >>> sh; end
                    FN_SLLV: begin wr = 1; idx = rd; val = b << a[4:0]; end
                    FN_SRLV: begin wr = 1; idx = rd; val = b >> a[4:0]; end
                    FN_SRAV: begin wr = 1; idx = rd; val = $signed(b) >>> a[4:0]; end
                    FN_MULT: begin
                        p = {{32{a[31]}}, a} * {{32{b[31]}}, b};
                        lo_q = p[31:0]; hi_q = p[63:32];
                    end
                    FN_MULTU: begin
                        p = {32'd0, a} * {32'd0, b};
                        lo_q = p[31:0]; hi_q = p[63:32];
                    end
                    FN_DIV: begin
                        if (b == 0) status = ST_DIVZERO;
                        else begin
                            // magnitudes, then signs; most negative by -1 wraps
                            ma = a[31] ? -a : a;
                            mb = b[31] ? -b : b;
                            q = ma / mb; m = ma % mb;
                            if (a[31] ^ b[31]) q = -q;
                            if (a[31]) m = -m;
                            lo_q = q; hi_q = m;
                        end
                    end
                    FN_DIVU: begin
                        if (b == 0) status = ST_DIVZERO;
                        else begin lo_q = a / b; hi_q = a % b; end
                    end
                    FN_MFHI: begin wr = 1; idx = rd; val = hi_q; end
                    FN_MFLO: begin wr = 1; idx = rd; val = lo_q; end
                    FN_MTHI: hi_q = a;
                    FN_MTLO: lo_q = a;
                    FN_JR: begin
                        if (a[1:0] != 0) status = ST_MISALIGN; else npc = a;
                    end
                    FN_JALR: begin
                        if (a[1:0] != 0) status = ST_MISALIGN;
                        else begin wr = 1; idx = rd; val = npc; npc = a; end
                    end
                    FN_SYSCALL: if (gpr[REG_V0] == SYSCALL_EXIT) halt_seen = 1'b1;
                    default: status = ST_UNKNOWN;
                endcase
            end
            OP_REGIMM: begin
                tgt = npc + (se << 2);
                case (rt)
                    RI_BLTZ: if (a[31]) npc = tgt;
                    RI_BGEZ: if (!a[31]) npc = tgt;
                    // link register is written whether or not the branch goes
                    RI_BLTZAL: begin wr = 1; idx = REG_RA; val = npc; if (a[31]) npc = tgt; end
                    RI_BGEZAL: begin wr = 1; idx = REG_RA; val = npc; if (!a[31]) npc = tgt; end
                    default: status = ST_UNKNOWN;
                endcase
            end
            OP_J: npc = {npc[31:28], ins[25:0], 2'b00};
            OP_JAL: begin
                wr = 1; idx = REG_RA; val = npc;
                npc = {npc[31:28], ins[25:0], 2'b00};
            end
            OP_BEQ:  if (a == b) npc = npc + (se << 2);
            OP_BNE:  if (a != b) npc = npc + (se << 2);
            OP_BLEZ: if (a[31] || a == 0) npc = npc + (se << 2);
            OP_BGTZ: if (!a[31] && a != 0) npc = npc + (se << 2);
            OP_ADDI: begin
                r = a + se;
                if (~(a[31] ^ se[31]) & (a[31] ^ r[31])) status = ST_OVERFLOW;
                else begin wr = 1; idx = rt; val = r; end
            end
            OP_ADDIU: begin wr = 1; idx = rt; val = a + se; end
            OP_SLTI:  begin wr = 1; idx = rt; val = ($signed(a) < $signed(se)); end
            OP_SLTIU: begin wr = 1; idx = rt; val = (a < se); end
            OP_ANDI:  begin wr = 1; idx = rt; val = a & {16'd0, imm}; end
            OP_ORI:   begin wr = 1; idx = rt; val = a | {16'd0, imm}; end
            OP_XORI:  begin wr = 1; idx = rt; val = a ^ {16'd0, imm}; end
            OP_LUI:   begin wr = 1; idx = rt; val = {imm, 16'd0}; end
            OP_LB, OP_LBU: begin
                lane = int'(addr[1:0]) * 8;
                w = (dmem[wi] >> lane) & 32'hFF;
                if (op == OP_LB && w[7]) w = w | 32'hFFFF_FF00;
                wr = 1; idx = rt; val = w;
            end
            OP_LH, OP_LHU: begin
                if (addr[0]) status = ST_MISALIGN;
                else begin
                    lane = int'(addr[1]) * 16;
                    w = (dmem[wi] >> lane) & 32'hFFFF;
                    if (op == OP_LH && w[15]) w = w | 32'hFFFF_0000;
                    wr = 1; idx = rt; val = w;
                end
            end
            OP_LW: begin
                if (addr[1:0] != 0) status = ST_MISALIGN;
                else begin wr = 1; idx = rt; val = dmem[wi]; end
            end
            OP_SB: begin
                lane = int'(addr[1:0]) * 8;
                dmem[wi] = (dmem[wi] & ~(32'hFF << lane)) | ((b & 32'hFF) << lane);
                st = 1;
            end
            OP_SH: begin
                if (addr[0]) status = ST_MISALIGN;
                else begin
                    lane = int'(addr[1]) * 16;
                    dmem[wi] = (dmem[wi] & ~(32'hFFFF << lane)) | ((b & 32'hFFFF) << lane);
                    st = 1;
                end
            end
            OP_SW: begin
                if (addr[1:0] != 0) status = ST_MISALIGN;
                else begin dmem[wi] = b; st = 1; end
            end
            default: status = ST_UNKNOWN;
        endcase
        if (st && !dmem_written[wi]) begin
            dmem_written[wi] = 1'b1;
            written_words.push_back(wi);
        end
        // r0 swallows writes
        if (wr && idx != 0) gpr[idx] = val;
        else begin wr = 0; idx = 0; val = 0; end
        pc_q = npc;
        res.npc = npc; res.wr = wr; res.idx = idx; res.val = val;
        res.st = st; res.status = status; res.halted = halt_seen;
        return res;
    endfunction

    // random word, mostly well formed; loads are steered onto stored words
    function automatic logic [31:0] random_word();
        logic [31:0] ins;
        logic [31:0] base;
        logic [11:0] low;
        logic [1:0]  lane;
        int          wi;
        ins = $urandom();
        if ($urandom_range(99) < 88) begin
            ins[31:26] = op_pool[$urandom_range(23)];
            if (ins[31:26] == OP_SPECIAL && $urandom_range(99) < 92)
                ins[5:0] = fn_pool[$urandom_range(26)];
            if (ins[31:26] == OP_REGIMM && $urandom_range(99) < 92)
                ins[20:16] = ri_pool[$urandom_range(3)];
        end
        if (ins[31:26] inside {OP_LB, OP_LH, OP_LW, OP_LBU, OP_LHU}) begin
            if (written_words.size() == 0) ins[31:26] = OP_SW;
            else begin
                wi = written_words[$urandom_range(written_words.size() - 1)];
                lane = ($urandom_range(99) < 50) ? 2'd0 : 2'($urandom_range(3));
                base = gpr[ins[25:21]];
                low = {wi[9:0], lane} - base[11:0];
                ins[11:0] = low;
            end
        end
        // the halting call is kept for the very end
        if (ins[31:26] == OP_SPECIAL && ins[5:0] == FN_SYSCALL && gpr[REG_V0] == SYSCALL_EXIT)
            ins[5:0] = FN_ADDU;
        return ins;
    endfunction

    // drive one request and wait until it is taken
    task automatic send_request(logic [31:0] ins, logic typed, exec_result_t typed_res);
        exec_result_t res;
        res = execute_word(ins);
        result_q.push_back(typed ? typed_res : res);
        requests_sent++;
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_instruction = ins;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    task automatic drop_valid();
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    // start address load, only with nothing in flight
    task automatic load_start(logic [31:0] addr);
        wait (result_q.size() == 0);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_data = addr;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        pc_q = addr;
    endtask

    task automatic random_phase(int count, int s_idle, int r_idle, logic [31:0] start);
        load_start(start);
        send_idle_pct = s_idle;
        recv_idle_pct = r_idle;
        for (int n = 0; n < count; n++) begin
            // one hold-off mid phase until the pipe has drained
            if (n == count / 2) begin
                drop_valid();
                wait (result_q.size() == 0);
            end
            send_request(random_word(), 1'b0, '0);
        end
        drop_valid();
    endtask

    // receiver back-pressure
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < recv_idle_pct);
    end

    // result checker
    always @(posedge i_clk) begin
        exec_result_t got, want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            got = '{o_next_pc, o_reg_written, o_reg_index, o_reg_value,
                    o_stored, o_status, o_halted};
            if (result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: pc %h wr %b r%0d=%h st %b status %0d halt %b",
                             got.npc, got.wr, got.idx, got.val, got.st, got.status,
                             got.halted);
            end else begin
                want = result_q.pop_front();
                results_checked++;
                if (got.npc !== want.npc || got.wr !== want.wr || got.idx !== want.idx ||
                    got.val !== want.val || got.st !== want.st ||
                    got.status !== want.status || got.halted !== want.halted) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch on result %0d", results_checked);
                        $display("  expected pc %h wr %b r%0d=%h st %b status %0d halt %b",
                                 want.npc, want.wr, want.idx, want.val, want.st,
                                 want.status, want.halted);
                        $display("  actual   pc %h wr %b r%0d=%h st %b status %0d halt %b",
                                 got.npc, got.wr, got.idx, got.val, got.st, got.status,
                                 got.halted);
                    end
                end
            end
        end
    end

    // watchdog: cycles without any request or result moving
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog expired with %0d results outstanding", result_q.size());
            $display("mips_integer_instruction_execute test failed");
            $finish;
        end
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_instruction = '0;
        i_out_stall = 1'b0;
        send_idle_pct = 36;
        recv_idle_pct = 79;
        mismatches = 0;
        requests_sent = 0;
        results_checked = 0;
        idle_cycles = 0;
        for (int k = 0; k < 32; k++) gpr[k] = '0;
        for (int k = 0; k < 1024; k++) begin
            dmem[k] = '0;
            dmem_written[k] = 1'b0;
        end
        pc_q = START_RESET;
        hi_q = '0;
        lo_q = '0;
        halt_seen = 1'b0;

        // directed table: straight-line code from the reset pc first, so the
        // early rows can be typed in by hand
        add_row(i_word(OP_ADDIU, 5'd0, 5'd1, 16'hFFFF), 1,
                typed_result(32'h0040_0004, 5'd1, 32'hFFFF_FFFF, ST_OK));
        add_row(i_word(OP_LUI, 5'd0, 5'd2, 16'h7FFF), 1,
                typed_result(32'h0040_0008, 5'd2, 32'h7FFF_0000, ST_OK));
        // ori zero-extends its immediate
        add_row(i_word(OP_ORI, 5'd2, 5'd2, 16'hFFFF), 1,
                typed_result(32'h0040_000C, 5'd2, 32'h7FFF_FFFF, ST_OK));
        add_row(r_word(5'd2, 5'd2, 5'd3, 5'd0, FN_ADD), 1,
                typed_result(32'h0040_0010, 5'd0, 32'd0, ST_OVERFLOW));
        add_row(i_word(OP_ADDI, 5'd2, 5'd4, 16'h0001), 1,
                typed_result(32'h0040_0014, 5'd0, 32'd0, ST_OVERFLOW));
        add_row(r_word(5'd1, 5'd0, 5'd0, 5'd0, FN_DIV), 1,
                typed_result(32'h0040_0018, 5'd0, 32'd0, ST_DIVZERO));
        add_row(32'hFFFF_FFFF, 1, typed_result(32'h0040_001C, 5'd0, 32'd0, ST_UNKNOWN));
        add_row(r_word(5'd1, 5'd2, 5'd3, 5'd0, 6'h3F), 1,
                typed_result(32'h0040_0020, 5'd0, 32'd0, ST_UNKNOWN));
        add_row(i_word(OP_REGIMM, 5'd1, 5'h1F, 16'h0000), 1,
                typed_result(32'h0040_0024, 5'd0, 32'd0, ST_UNKNOWN));
        // writes to r0 are discarded
        add_row(r_word(5'd1, 5'd1, 5'd0, 5'd0, FN_ADDU), 1,
                typed_result(32'h0040_0028, 5'd0, 32'd0, ST_OK));
        add_row(r_word(5'd1, 5'd2, 5'd3, 5'd0, FN_SUB), 0, '0);
        // most negative divided by minus one
        add_row(i_word(OP_LUI, 5'd0, 5'd5, 16'h8000), 0, '0);
        add_row(r_word(5'd5, 5'd1, 5'd0, 5'd0, FN_DIV), 0, '0);
        add_row(r_word(5'd0, 5'd0, 5'd7, 5'd0, FN_MFLO), 0, '0);
        add_row(r_word(5'd0, 5'd0, 5'd8, 5'd0, FN_MFHI), 0, '0);
        add_row(r_word(5'd1, 5'd2, 5'd0, 5'd0, FN_MULT), 0, '0);
        add_row(i_word(OP_SLTIU, 5'd2, 5'd14, 16'hFFFF), 0, '0);
        // byte and halfword lanes of one stored word
        add_row(i_word(OP_SW, 5'd0, 5'd5, 16'h0010), 0, '0);
        add_row(i_word(OP_SB, 5'd0, 5'd2, 16'h0011), 0, '0);
        add_row(i_word(OP_SH, 5'd0, 5'd1, 16'h0012), 0, '0);
        add_row(i_word(OP_LB, 5'd0, 5'd9, 16'h0013), 0, '0);
        add_row(i_word(OP_LH, 5'd0, 5'd10, 16'h0012), 0, '0);
        add_row(i_word(OP_LHU, 5'd0, 5'd11, 16'h0012), 0, '0);
        add_row(i_word(OP_LBU, 5'd0, 5'd12, 16'h0011), 0, '0);
        add_row(i_word(OP_LW, 5'd0, 5'd13, 16'h0011), 0, '0);
        add_row(r_word(5'd1, 5'd0, 5'd0, 5'd0, FN_JR), 0, '0);
        // link written, branch taken backwards
        add_row(i_word(OP_REGIMM, 5'd1, RI_BLTZAL, 16'hFFFF), 0, '0);
        add_row(r_word(5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL), 0, '0);
        add_row(r_word(5'd0, 5'd0, 5'd31, 5'd0, FN_JALR), 0, '0);

        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[n]) send_request(dir_rows[n].ins, dir_rows[n].typed, dir_rows[n].res);
        drop_valid();

        random_phase(215, 36, 79, 32'hFFFF_FFFF);
        random_phase(215, 79, 36, 32'h0000_0000);
        random_phase(215, 0, 0, 32'h8000_0000);

        // halting call, then a few words that must change nothing
        send_idle_pct = 36;
        recv_idle_pct = 36;
        send_request(i_word(OP_ADDIU, 5'd0, REG_V0, 16'd10), 1'b0, '0);
        send_request(r_word(5'd0, 5'd0, 5'd0, 5'd0, FN_SYSCALL), 1'b0, '0);
        repeat (4) send_request(random_word(), 1'b0, '0);
        drop_valid();

        wait (result_q.size() == 0);
        repeat (50) @(posedge i_clk);

        $display("%0d instruction requests over three start addresses and idle mixes,",
                 requests_sent);
        $display("%0d results checked, %0d mismatches, halt reached at the end",
                 results_checked, mismatches);
        if (mismatches == 0 && result_q.size() == 0) begin
            $display("mips_integer_instruction_execute test passed");
        end else begin
            $display("mips_integer_instruction_execute test failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
src/mie_pkg.sv
src/mie_ram.sv
src/mie_muldiv.sv
src/mips_integer_instruction_execute.sv
tb/testbench.sv
